>>> design/hsv2rgb_pkg.sv
// Shared types and fixed field widths for the HSV to RGB pixel converter.
// No dependencies; the hue, channel and top design files refer to it by scoped names.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Fixed port field widths.
  localparam int HUE_W    = 16;
  localparam int SV_W     = 8;
  localparam int CH_W     = 8;
  localparam int PACKED_W = 24;

  // Width of the sector weight between the hue and channel units.
  // It holds the full sector span for every supported hue fraction.
  localparam int K_W = 16;

  // Hue sector, named by the primary and secondary channel.
  typedef enum logic [2:0] {
    SECT_RG = 3'd0,
    SECT_GR = 3'd1,
    SECT_GB = 3'd2,
    SECT_BG = 3'd3,
    SECT_BR = 3'd4,
    SECT_RB = 3'd5
  } sector_t;

endpackage

>>> design/hsv2rgb_cdiv.sv
// Three-stage pipelined unsigned division by a constant.
// Uses a reciprocal multiply, a back-multiply and one correction step.
`timescale 1ns / 1ps

module hsv2rgb_cdiv #(
  parameter int              XW      = 16,
  parameter longint unsigned DIVISOR = 5760
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [XW-1:0] q,
  output logic [XW-1:0] rem
);

  localparam longint unsigned MULT = (64'd1 << XW) / DIVISOR;
  localparam int              MW   = (MULT > 1) ? $clog2(MULT + 1) : 1;
  localparam longint unsigned QMAX = ((64'd1 << XW) - 1) / DIVISOR;
  localparam int              QW   = (QMAX > 1) ? $clog2(QMAX + 1) : 1;
  localparam int              DW   = $clog2(DIVISOR + 1);
  localparam int              CW   = (XW > DW) ? XW : DW;
  localparam int              FW   = XW + QW + DW;
  localparam int              PW   = XW + MW;

  localparam logic [MW-1:0] MULT_C = MW'(MULT);
  localparam logic [FW-1:0] DIV_F  = FW'(DIVISOR);
  localparam logic [CW-1:0] DIV_C  = CW'(DIVISOR);

  logic [PW-1:0] prod;
  logic [XW-1:0] x1;
  logic [QW-1:0] q_est;
  logic [FW-1:0] qd_full;
  logic [QW-1:0] q2;
  logic [XW-1:0] x2;
  logic [XW-1:0] qd2;
  logic [XW-1:0] rem0;

  // The estimate is never above the true quotient and at most one below it.
  assign q_est   = prod[XW +: QW];
  assign qd_full = FW'(q_est) * DIV_F;
  assign rem0    = x2 - qd2;

  // Stage one multiplies by the reciprocal, stage two multiplies back,
  // and stage three forms the remainder and corrects the estimate.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(x) * PW'(MULT_C);
      x1   <= x;
      q2   <= q_est;
      x2   <= x1;
      qd2  <= qd_full[XW-1:0];
      if (CW'(rem0) >= DIV_C) begin
        q   <= XW'(q2) + XW'(1);
        rem <= rem0 - DIV_C[XW-1:0];
      end else begin
        q   <= XW'(q2);
        rem <= rem0;
      end
    end
  end

endmodule

>>> design/hsv2rgb_hue.sv
// Hue unit: reduces the hue modulo a full turn, then finds the sector and
// the in-sector weight. Depends on hsv2rgb_pkg and hsv2rgb_cdiv.
`timescale 1ns / 1ps

module hsv2rgb_hue #(
  parameter int HUE_FRACTION_BITS = 4
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
  output hsv2rgb_pkg::sector_t          sector,
  output logic [hsv2rgb_pkg::K_W-1:0]   k
);

  localparam int SEC  = 60 << HUE_FRACTION_BITS;
  localparam int TURN = 360 << HUE_FRACTION_BITS;
  localparam int SECW = $clog2(SEC + 1);
  localparam int HCW  = $clog2(TURN) + 1;

  localparam logic [HCW-1:0]  SEC1   = HCW'(SEC);
  localparam logic [HCW-1:0]  SEC2   = HCW'(2 * SEC);
  localparam logic [HCW-1:0]  SEC3   = HCW'(3 * SEC);
  localparam logic [HCW-1:0]  SEC4   = HCW'(4 * SEC);
  localparam logic [HCW-1:0]  SEC5   = HCW'(5 * SEC);
  localparam logic [SECW-1:0] SEC_C  = SECW'(SEC);

  logic [hsv2rgb_pkg::HUE_W-1:0] hred;
  logic [HCW-1:0]                hx;
  logic [HCW-1:0]                base;
  logic [HCW-1:0]                roff;
  logic [SECW-1:0]               r;
  logic                          odd;
  hsv2rgb_pkg::sector_t          sector_next;
  logic [SECW-1:0]               k_next;

  // Hue modulo a full turn, three stages.
  hsv2rgb_cdiv #(
    .XW      (hsv2rgb_pkg::HUE_W),
    .DIVISOR (TURN)
  ) u_turn (
    .clk (clk),
    .en  (en),
    .x   (hue),
    .q   (),
    .rem (hred)
  );

  // The reduced hue is below a full turn, so it fits the compare width.
  assign hx = HCW'(hred);

  // Sector search over the five boundaries.
  always_comb begin
    priority if (hx >= SEC5) begin
      sector_next = hsv2rgb_pkg::SECT_RB;
      base        = SEC5;
      odd         = 1'b1;
    end else if (hx >= SEC4) begin
      sector_next = hsv2rgb_pkg::SECT_BR;
      base        = SEC4;
      odd         = 1'b0;
    end else if (hx >= SEC3) begin
      sector_next = hsv2rgb_pkg::SECT_BG;
      base        = SEC3;
      odd         = 1'b1;
    end else if (hx >= SEC2) begin
      sector_next = hsv2rgb_pkg::SECT_GB;
      base        = SEC2;
      odd         = 1'b0;
    end else if (hx >= SEC1) begin
      sector_next = hsv2rgb_pkg::SECT_GR;
      base        = SEC1;
      odd         = 1'b1;
    end else begin
      sector_next = hsv2rgb_pkg::SECT_RG;
      base        = '0;
      odd         = 1'b0;
    end
  end

  // Weight rises through even sectors and falls through odd ones.
  assign roff   = hx - base;
  assign r      = roff[SECW-1:0];
  assign k_next = odd ? (SEC_C - r) : r;

  // Stage four registers.
  always_ff @(posedge clk) begin
    if (en) begin
      sector <= sector_next;
      k      <= hsv2rgb_pkg::K_W'(k_next);
    end
  end

endmodule

>>> design/hsv2rgb_chan.sv
// Channel unit: computes the secondary and the lowest channel values from
// saturation, brightness and the sector weight. Depends on hsv2rgb_pkg and
// hsv2rgb_cdiv.
`timescale 1ns / 1ps

module hsv2rgb_chan #(
  parameter int HUE_FRACTION_BITS = 4,
  parameter int CHANNEL_BITS      = 8
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hsv2rgb_pkg::SV_W-1:0] saturation,
  input  logic [hsv2rgb_pkg::SV_W-1:0] brightness,
  input  logic [hsv2rgb_pkg::K_W-1:0]  k,
  output logic [hsv2rgb_pkg::CH_W-1:0] sec_val,
  output logic [hsv2rgb_pkg::CH_W-1:0] zero_val
);

  localparam int SVW  = (CHANNEL_BITS < hsv2rgb_pkg::SV_W) ? CHANNEL_BITS
                                                          : hsv2rgb_pkg::SV_W;
  localparam int AW   = SVW + CHANNEL_BITS;
  localparam int BW   = 2 * SVW;
  localparam int SEC  = 60 << HUE_FRACTION_BITS;
  localparam int SECW = $clog2(SEC + 1);
  localparam int KW   = BW + SECW;
  localparam longint unsigned CMAX = (64'd1 << CHANNEL_BITS) - 1;

  localparam logic [CHANNEL_BITS-1:0] CMAX_C = '1;

  logic [SVW-1:0]          s_eff;
  logic [SVW-1:0]          v_eff;
  logic [CHANNEL_BITS-1:0] cms;
  logic [AW-1:0]           a_pipe [1:9];
  logic [BW-1:0]           b_pipe [1:4];
  logic [KW-1:0]           bk;
  logic [KW-1:0]           t_q;
  logic [AW-1:0]           y;
  logic [AW-1:0]           sec_q;
  logic [AW-1:0]           zero_q;

  // Only the low channel bits of saturation and brightness count.
  assign s_eff = saturation[SVW-1:0];
  assign v_eff = brightness[SVW-1:0];
  assign cms   = CMAX_C - CHANNEL_BITS'(s_eff);

  // Stage one forms v*(max-s) and v*s; stage five weights v*s by the hue;
  // stage nine adds the floored weighted term to v*(max-s).
  always_ff @(posedge clk) begin
    if (en) begin
      a_pipe[1] <= AW'(v_eff) * AW'(cms);
      b_pipe[1] <= BW'(v_eff) * BW'(s_eff);
      for (int i = 2; i <= 9; i++) begin
        a_pipe[i] <= a_pipe[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
        b_pipe[i] <= b_pipe[i-1];
      end
      bk <= KW'(b_pipe[4]) * KW'(k[SECW-1:0]);
      y  <= a_pipe[8] + AW'(t_q[BW-1:0]);
    end
  end

  // Weighted term divided by the sector span, stages six to eight.
  hsv2rgb_cdiv #(
    .XW      (KW),
    .DIVISOR (SEC)
  ) u_span (
    .clk (clk),
    .en  (en),
    .x   (bk),
    .q   (t_q),
    .rem ()
  );

  // Secondary channel divided by the channel maximum, stages ten to twelve.
  hsv2rgb_cdiv #(
    .XW      (AW),
    .DIVISOR (CMAX)
  ) u_sec (
    .clk (clk),
    .en  (en),
    .x   (y),
    .q   (sec_q),
    .rem ()
  );

  // Lowest channel divided by the channel maximum, in step with the above.
  hsv2rgb_cdiv #(
    .XW      (AW),
    .DIVISOR (CMAX)
  ) u_zero (
    .clk (clk),
    .en  (en),
    .x   (a_pipe[9]),
    .q   (zero_q),
    .rem ()
  );

  // Both results are at most the brightness.
  assign sec_val  = hsv2rgb_pkg::CH_W'(sec_q[SVW-1:0]);
  assign zero_val = hsv2rgb_pkg::CH_W'(zero_q[SVW-1:0]);

endmodule

>>> design/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter, 13-stage pipeline.
// Throughput is one pixel per cycle; the whole pipeline holds while an
// output word waits, so only the output ready can stall it.
// Synchronous reset clears the stage valid bits; data registers keep values.
// Depends on hsv2rgb_pkg, hsv2rgb_hue, hsv2rgb_chan and hsv2rgb_cdiv.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel #(
  parameter int HUE_FRACTION_BITS = 4,
  parameter int CHANNEL_BITS      = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]    hue,
  input  logic [hsv2rgb_pkg::SV_W-1:0]     saturation,
  input  logic [hsv2rgb_pkg::SV_W-1:0]     brightness,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hsv2rgb_pkg::CH_W-1:0]     red,
  output logic [hsv2rgb_pkg::CH_W-1:0]     green,
  output logic [hsv2rgb_pkg::CH_W-1:0]     blue,
  output logic [hsv2rgb_pkg::PACKED_W-1:0] packed_rgb
);

  localparam int LAT = 13;
  localparam int SVW = (CHANNEL_BITS < hsv2rgb_pkg::SV_W) ? CHANNEL_BITS
                                                         : hsv2rgb_pkg::SV_W;
  localparam int PW  = (2 * CHANNEL_BITS + hsv2rgb_pkg::CH_W > hsv2rgb_pkg::PACKED_W)
                       ? 2 * CHANNEL_BITS + hsv2rgb_pkg::CH_W
                       : hsv2rgb_pkg::PACKED_W;

  logic                            en;
  logic                            vld [1:LAT];
  logic [SVW-1:0]                  v_pipe [1:12];
  hsv2rgb_pkg::sector_t            sect_pipe [5:12];
  hsv2rgb_pkg::sector_t            sector4;
  logic [hsv2rgb_pkg::K_W-1:0]     k4;
  logic [hsv2rgb_pkg::CH_W-1:0]    prim;
  logic [hsv2rgb_pkg::CH_W-1:0]    sec_val;
  logic [hsv2rgb_pkg::CH_W-1:0]    zero_val;
  logic [hsv2rgb_pkg::CH_W-1:0]    red_next;
  logic [hsv2rgb_pkg::CH_W-1:0]    green_next;
  logic [hsv2rgb_pkg::CH_W-1:0]    blue_next;
  logic [PW-1:0]                   packed_full;

  // The pipeline advances unless a finished word is waiting at the output.
  assign en        = !vld[LAT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT];

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= in_valid;
      for (int i = 2; i <= LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Hue reduction and sector search, result at stage four.
  hsv2rgb_hue #(
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_hue (
    .clk    (clk),
    .en     (en),
    .hue    (hue),
    .sector (sector4),
    .k      (k4)
  );

  // Secondary and lowest channel values, result at stage twelve.
  hsv2rgb_chan #(
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .CHANNEL_BITS      (CHANNEL_BITS)
  ) u_chan (
    .clk        (clk),
    .en         (en),
    .saturation (saturation),
    .brightness (brightness),
    .k          (k4),
    .sec_val    (sec_val),
    .zero_val   (zero_val)
  );

  // Brightness and sector travel alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (en) begin
      v_pipe[1] <= brightness[SVW-1:0];
      for (int i = 2; i <= 12; i++) begin
        v_pipe[i] <= v_pipe[i-1];
      end
      sect_pipe[5] <= sector4;
      for (int i = 6; i <= 12; i++) begin
        sect_pipe[i] <= sect_pipe[i-1];
      end
    end
  end

  assign prim = hsv2rgb_pkg::CH_W'(v_pipe[12]);

  // Sector table: route primary, secondary and lowest values to channels.
  always_comb begin
    unique case (sect_pipe[12])
      hsv2rgb_pkg::SECT_RG: begin
        red_next = prim;     green_next = sec_val;  blue_next = zero_val;
      end
      hsv2rgb_pkg::SECT_GR: begin
        red_next = sec_val;  green_next = prim;     blue_next = zero_val;
      end
      hsv2rgb_pkg::SECT_GB: begin
        red_next = zero_val; green_next = prim;     blue_next = sec_val;
      end
      hsv2rgb_pkg::SECT_BG: begin
        red_next = zero_val; green_next = sec_val;  blue_next = prim;
      end
      hsv2rgb_pkg::SECT_BR: begin
        red_next = sec_val;  green_next = zero_val; blue_next = prim;
      end
      default: begin
        red_next = prim;     green_next = zero_val; blue_next = sec_val;
      end
    endcase
  end

  // Channels packed at the channel pitch, kept to the field width.
  assign packed_full = (PW'(red_next) << (2 * CHANNEL_BITS))
                     | (PW'(green_next) << CHANNEL_BITS)
                     | PW'(blue_next);

  // Output word register.
  always_ff @(posedge clk) begin
    if (en) begin
      red        <= red_next;
      green      <= green_next;
      blue       <= blue_next;
      packed_rgb <= packed_full[hsv2rgb_pkg::PACKED_W-1:0];
    end
  end

endmodule

>>> verif/hsv_to_rgb_pixel_tb.sv
// Self-checking testbench for the HSV to RGB pixel converter (hsv_to_rgb_pixel).
// Drives directed and random pixels, predicts every RGB word and compares it in order.
// Depends on hsv2rgb_pkg and the design sources of hsv_to_rgb_pixel.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_tb;

  localparam int HUE_FRAC     = 4;
  localparam int CHAN_BITS    = 8;
  localparam int PIPE_LATENCY = 13;
  localparam int STALL_LIMIT  = 2000;

  // Hue span of one sector and of a full turn, in hue units.
  localparam longint unsigned SECTOR_SPAN = 64'd60 << HUE_FRAC;
  localparam longint unsigned TURN_SPAN   = 64'd360 << HUE_FRAC;
  localparam longint unsigned CHAN_MAX    = (64'd1 << CHAN_BITS) - 64'd1;

  typedef struct packed {
    logic [hsv2rgb_pkg::CH_W-1:0]     red;
    logic [hsv2rgb_pkg::CH_W-1:0]     green;
    logic [hsv2rgb_pkg::CH_W-1:0]     blue;
    logic [hsv2rgb_pkg::PACKED_W-1:0] packed_rgb;
  } rgb_word_t;

  logic                             clk        = 1'b0;
  logic                             rst        = 1'b1;
  logic                             in_valid   = 1'b0;
  logic                             in_ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]    hue        = '0;
  logic [hsv2rgb_pkg::SV_W-1:0]     saturation = '0;
  logic [hsv2rgb_pkg::SV_W-1:0]     brightness = '0;
  logic                             out_valid;
  logic                             out_ready  = 1'b0;
  logic [hsv2rgb_pkg::CH_W-1:0]     red;
  logic [hsv2rgb_pkg::CH_W-1:0]     green;
  logic [hsv2rgb_pkg::CH_W-1:0]     blue;
  logic [hsv2rgb_pkg::PACKED_W-1:0] packed_rgb;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int stall_cycles  = 0;

  rgb_word_t expected_rgb_q[$];

  hsv_to_rgb_pixel #(
    .HUE_FRACTION_BITS(HUE_FRAC),
    .CHANNEL_BITS(CHAN_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .packed_rgb(packed_rgb)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Computes the RGB word for one HSV pixel with exact integer arithmetic.
  // Each channel is one rational value truncated once.
  function automatic rgb_word_t hsv_pixel_to_rgb(logic [hsv2rgb_pkg::HUE_W-1:0] h_in,
                                                 logic [hsv2rgb_pkg::SV_W-1:0] s_in,
                                                 logic [hsv2rgb_pkg::SV_W-1:0] v_in);
    longint unsigned      h, s, v, phase, gap, weight;
    longint unsigned      full_ch, mixed_ch, floor_ch, r, g, b;
    hsv2rgb_pkg::sector_t sect;
    rgb_word_t            word;
    h        = longint'(h_in) % TURN_SPAN;
    s        = longint'(s_in) & CHAN_MAX;
    v        = longint'(v_in) & CHAN_MAX;
    sect     = hsv2rgb_pkg::sector_t'(h / SECTOR_SPAN);
    phase    = h % (2 * SECTOR_SPAN);
    gap      = (phase >= SECTOR_SPAN) ? phase - SECTOR_SPAN : SECTOR_SPAN - phase;
    weight   = SECTOR_SPAN - gap;
    full_ch  = v;
    mixed_ch = (v * (CHAN_MAX - s) * SECTOR_SPAN + v * s * weight) /
               (CHAN_MAX * SECTOR_SPAN);
    floor_ch = (v * (CHAN_MAX - s)) / CHAN_MAX;
    case (sect)
      hsv2rgb_pkg::SECT_RG: begin r = full_ch;  g = mixed_ch; b = floor_ch; end
      hsv2rgb_pkg::SECT_GR: begin r = mixed_ch; g = full_ch;  b = floor_ch; end
      hsv2rgb_pkg::SECT_GB: begin r = floor_ch; g = full_ch;  b = mixed_ch; end
      hsv2rgb_pkg::SECT_BG: begin r = floor_ch; g = mixed_ch; b = full_ch;  end
      hsv2rgb_pkg::SECT_BR: begin r = mixed_ch; g = floor_ch; b = full_ch;  end
      default: begin r = full_ch;  g = floor_ch; b = mixed_ch; end
    endcase
    word.red        = r[hsv2rgb_pkg::CH_W-1:0];
    word.green      = g[hsv2rgb_pkg::CH_W-1:0];
    word.blue       = b[hsv2rgb_pkg::CH_W-1:0];
    word.packed_rgb = hsv2rgb_pkg::PACKED_W'((r << (2 * CHAN_BITS)) | (g << CHAN_BITS) | b);
    return word;
  endfunction

  task automatic compare_field(string field, logic [hsv2rgb_pkg::PACKED_W-1:0] want,
                               logic [hsv2rgb_pkg::PACKED_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Output drain side: ready follows the current idle percentage.
  always @(posedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Records each accepted input word and checks each accepted output word.
  always @(posedge clk) begin : scoreboard
    rgb_word_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_rgb_q.push_back(hsv_pixel_to_rgb(hue, saturation, brightness));
      if (out_valid && out_ready) begin
        if (expected_rgb_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0h", $time, packed_rgb);
          fail_count++;
        end else begin
          want = expected_rgb_q.pop_front();
          compare_field("red", hsv2rgb_pkg::PACKED_W'(want.red),
                        hsv2rgb_pkg::PACKED_W'(red));
          compare_field("green", hsv2rgb_pkg::PACKED_W'(want.green),
                        hsv2rgb_pkg::PACKED_W'(green));
          compare_field("blue", hsv2rgb_pkg::PACKED_W'(want.blue),
                        hsv2rgb_pkg::PACKED_W'(blue));
          compare_field("packed_rgb", want.packed_rgb, packed_rgb);
        end
      end
    end
  end

  // Ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Presents one pixel, after an optional random gap, and waits for acceptance.
  task automatic send_pixel(logic [hsv2rgb_pkg::HUE_W-1:0] h,
                            logic [hsv2rgb_pkg::SV_W-1:0] s,
                            logic [hsv2rgb_pkg::SV_W-1:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Full, zero and single-step saturation and brightness, plus alternating bits.
  task automatic test_color_extremes();
    send_pixel(16'd0, 8'd255, 8'd255);
    send_pixel(16'd0, 8'd0, 8'd255);
    send_pixel(16'd0, 8'd255, 8'd0);
    send_pixel(16'd0, 8'd0, 8'd0);
    send_pixel(16'd480, 8'd128, 8'd255);
    send_pixel(16'd1440, 8'd1, 8'd1);
    send_pixel(16'hAAAA, 8'h55, 8'hAA);
    send_pixel(16'h5555, 8'hAA, 8'h55);
  endtask

  // Hue units on each side of the five inner sector boundaries.
  task automatic test_sector_edges();
    for (int i = 1; i < 6; i++) begin
      send_pixel(hsv2rgb_pkg::HUE_W'(i * SECTOR_SPAN), 8'd255, 8'd255);
      send_pixel(hsv2rgb_pkg::HUE_W'(i * SECTOR_SPAN - 1), 8'd200, 8'd180);
    end
  endtask

  // Hue just below, at and beyond a full turn; values from a full turn up are folded back into range.
  task automatic test_hue_wrap();
    send_pixel(hsv2rgb_pkg::HUE_W'(TURN_SPAN - 1), 8'd255, 8'd255);
    send_pixel(hsv2rgb_pkg::HUE_W'(TURN_SPAN), 8'd255, 8'd255);
    send_pixel(16'hFFFF, 8'd255, 8'd255);
  endtask

  function automatic logic [hsv2rgb_pkg::SV_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return hsv2rgb_pkg::SV_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [hsv2rgb_pkg::HUE_W-1:0] pick_hue();
    int edge_hue;
    case ($urandom_range(3))
      0: return hsv2rgb_pkg::HUE_W'($urandom_range(int'(TURN_SPAN) - 1));
      1: begin
        // Within a couple of units of a sector edge, possibly several turns up.
        edge_hue = $urandom_range(5) * int'(SECTOR_SPAN) + $urandom_range(4) - 2;
        if (edge_hue < 0)
          edge_hue += int'(TURN_SPAN);
        return hsv2rgb_pkg::HUE_W'(edge_hue + int'(TURN_SPAN) * $urandom_range(10));
      end
      default: return hsv2rgb_pkg::HUE_W'($urandom());
    endcase
  endfunction

  task automatic test_random_pixels(int count, int send_idle, int recv_idle);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    repeat (count) send_pixel(pick_hue(), pick_level(), pick_level());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_color_extremes();
    test_sector_edges();
    test_hue_wrap();
    test_random_pixels(650, 21, 62);
    test_random_pixels(650, 62, 21);
    test_random_pixels(650, 0, 0);
    in_valid <= 1'b0;

    // Drain every outstanding word, then watch for stray output words.
    while (expected_rgb_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
